// ===== src/ssf_pkg.sv =====
// shared types and constants of the selectable smoothing filter
`default_nettype none

package ssf_pkg;

   localparam int COEF_BITS        = 32;
   localparam int CSR_DATA_BITS    = 32;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int MODE_BITS        = 2;
   localparam int SMOOTH_BITS      = 17;
   localparam int SMOOTH_FRAC_BITS = 16;

   localparam logic [SMOOTH_BITS-1:0] SMOOTH_ONE = SMOOTH_BITS'(1) << SMOOTH_FRAC_BITS;

   localparam logic [MODE_BITS-1:0] MODE_PASS   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_SMOOTH = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_THIRD  = 2'd2;

   localparam logic OP_FILTER  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MODE      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SMOOTHING = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_Y    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DAMP_Y    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_Z    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_X    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INIT      = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_DONE  = 4'b1000
   } seq_state_type;

   typedef enum logic [4:0] {
      MAC_IDLE = 5'b00001,
      MAC_LO   = 5'b00010,
      MAC_HI   = 5'b00100,
      MAC_ADD  = 5'b01000,
      MAC_RND  = 5'b10000
   } mac_phase_type;

   typedef enum logic [5:0] {
      STEP_INIT_RATE = 6'b000001,
      STEP_SMOOTH    = 6'b000010,
      STEP_DAMP      = 6'b000100,
      STEP_LEVEL     = 6'b001000,
      STEP_RATE      = 6'b010000,
      STEP_OUT       = 6'b100000
   } step_type;

   typedef struct packed {
      logic start;
      logic frac16;
   } mac_ctl_type;

endpackage

`default_nettype wire

// ===== src/selectable_smoothing_filter.sv =====
// top level: configuration registers, filter state and the step sequencer
//
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_operation, req_sample
// rsp       out        rsp_valid/rsp_stall  rsp_filtered
// csr       in         csr_we               csr_index, csr_wdata
//
// one multiply on the shared unit runs through issue, four phases and write back
// third-order sample: four multiplies per item, first order and third-order restart: one,
// pass-through and other restarts: none
// synchronous reset clears config registers, x, y, z and control, with no clearing pass
// the result sits in an output register; a stalled rsp holds the next item in its
// final cycle and req stays stalled for the whole item
`default_nettype none

module selectable_smoothing_filter
   import ssf_pkg::*;
#(
   parameter int SAMPLE_BITS     = 24,
   parameter int COEF_FRAC_BITS  = 30,
   parameter int STATE_FRAC_BITS = 24
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire                                  req_operation,
   input  wire logic signed [SAMPLE_BITS-1:0]   req_sample,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]        rsp_filtered,
   input  wire                                  csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]       csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]        csr_wdata
);

   localparam int SB  = SAMPLE_BITS + STATE_FRAC_BITS;
   localparam int OPW = SB + 1;

   localparam logic signed [SB:0] OUT_HALF = (SB + 1)'(1) << (STATE_FRAC_BITS - 1);
   localparam logic signed [SB-1:0] ST_MAX = {1'b0, {(SB - 1){1'b1}}};
   localparam logic signed [SB-1:0] ST_MIN = {1'b1, {(SB - 1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   function automatic logic signed [OPW-1:0] ext(input logic signed [SB-1:0] a);
      return {a[SB-1], a};
   endfunction

   function automatic logic signed [SB-1:0] sat(input logic signed [OPW-1:0] a);
      logic signed [SB-1:0] r;
      if (a[OPW-1] != a[OPW-2]) begin
         r = a[OPW-1] ? ST_MIN : ST_MAX;
      end else begin
         r = a[SB-1:0];
      end
      return r;
   endfunction

   logic [MODE_BITS-1:0] mode_ff, mode_in;
   logic [SMOOTH_BITS-1:0] smoothing_ff, smoothing_in;
   logic [COEF_BITS-1:0] step_y_ff, step_y_in;
   logic [COEF_BITS-1:0] damp_y_ff, damp_y_in;
   logic [COEF_BITS-1:0] gain_z_ff, gain_z_in;
   logic [COEF_BITS-1:0] gain_x_ff, gain_x_in;
   logic signed [SAMPLE_BITS-1:0] init_ff, init_in;

   seq_state_type state_ff, state_in;
   step_type step_ff, step_in;
   logic signed [SB-1:0] x_ff, x_in;
   logic signed [SB-1:0] y_ff, y_in;
   logic signed [SB-1:0] z_ff, z_in;
   logic signed [SB-1:0] dy_ff, dy_in;
   logic signed [SB-1:0] delta_ff, delta_in;
   logic signed [SB-1:0] v_ff, v_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered_ff, rsp_filtered_in;

   mac_ctl_type mac_ctl;
   logic signed [OPW-1:0] mac_operand;
   logic [COEF_BITS-1:0] mac_coef;
   logic mac_done;
   logic signed [SB-1:0] mac_res;

   logic signed [SB-1:0] v_cur;
   logic signed [SB-1:0] iv;
   logic [SMOOTH_BITS-1:0] d_clamp;
   logic req_xfer;
   logic out_free;
   logic signed [SB:0] out_r;
   logic signed [SAMPLE_BITS:0] out_q;
   logic signed [SAMPLE_BITS-1:0] out_sat;

   assign v_cur    = {req_sample, {STATE_FRAC_BITS{1'b0}}};
   assign iv       = {init_ff, {STATE_FRAC_BITS{1'b0}}};
   assign d_clamp  = (smoothing_ff > SMOOTH_ONE) ? SMOOTH_ONE : smoothing_ff;
   assign req_xfer = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // round half up to sample units, then clamp to the sample range
   assign out_r = ext(x_ff) + OUT_HALF;
   assign out_q = out_r[SB:STATE_FRAC_BITS];
   assign out_sat = (out_q[SAMPLE_BITS] != out_q[SAMPLE_BITS-1]) ?
                    (out_q[SAMPLE_BITS] ? S_MIN : S_MAX) : out_q[SAMPLE_BITS-1:0];

   // config writes
   always_comb begin
      mode_in      = mode_ff;
      smoothing_in = smoothing_ff;
      step_y_in    = step_y_ff;
      damp_y_in    = damp_y_ff;
      gain_z_in    = gain_z_ff;
      gain_x_in    = gain_x_ff;
      init_in      = init_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MODE:      mode_in      = csr_wdata[MODE_BITS-1:0];
            REG_SMOOTHING: smoothing_in = csr_wdata[SMOOTH_BITS-1:0];
            REG_STEP_Y:    step_y_in    = csr_wdata[COEF_BITS-1:0];
            REG_DAMP_Y:    damp_y_in    = csr_wdata[COEF_BITS-1:0];
            REG_GAIN_Z:    gain_z_in    = csr_wdata[COEF_BITS-1:0];
            REG_GAIN_X:    gain_x_in    = csr_wdata[COEF_BITS-1:0];
            REG_INIT:      init_in      = csr_wdata[SAMPLE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // operand select for the shared unit
   always_comb begin
      mac_ctl.start  = (state_ff == ST_ISSUE);
      mac_ctl.frac16 = 1'b0;
      mac_operand    = ext(y_ff);
      mac_coef       = damp_y_ff;
      case (step_ff)
         STEP_INIT_RATE: begin
            mac_operand = ext(y_ff);
            mac_coef    = damp_y_ff;
         end
         STEP_SMOOTH: begin
            mac_operand    = ext(x_ff) - ext(v_ff);
            mac_coef       = COEF_BITS'(d_clamp);
            mac_ctl.frac16 = 1'b1;
         end
         STEP_DAMP: begin
            mac_operand = ext(y_ff);
            mac_coef    = damp_y_ff;
         end
         STEP_LEVEL: begin
            mac_operand = ext(dy_ff);
            mac_coef    = step_y_ff;
         end
         STEP_RATE: begin
            mac_operand = ext(delta_ff);
            mac_coef    = gain_z_ff;
         end
         STEP_OUT: begin
            mac_operand = ext(y_ff) - ext(x_ff);
            mac_coef    = gain_x_ff;
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      z_in            = z_ff;
      dy_in           = dy_ff;
      delta_in        = delta_ff;
      v_in            = v_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_filtered_in = rsp_filtered_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               v_in = v_cur;
               if (req_operation == OP_RESTART) begin
                  if (mode_ff == MODE_THIRD) begin
                     x_in     = iv;
                     y_in     = iv;
                     step_in  = STEP_INIT_RATE;
                     state_in = ST_ISSUE;
                  end else begin
                     x_in     = '0;
                     y_in     = '0;
                     z_in     = '0;
                     state_in = ST_DONE;
                  end
               end else if (mode_ff == MODE_SMOOTH) begin
                  step_in  = STEP_SMOOTH;
                  state_in = ST_ISSUE;
               end else if (mode_ff == MODE_THIRD) begin
                  delta_in = sat(ext(v_cur) - ext(y_ff));
                  step_in  = STEP_DAMP;
                  state_in = ST_ISSUE;
               end else begin
                  x_in     = v_cur;
                  state_in = ST_DONE;
               end
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mac_done) begin
               state_in = ST_DONE;
               case (step_ff)
                  STEP_INIT_RATE: begin
                     z_in = mac_res;
                  end
                  STEP_SMOOTH: begin
                     x_in = sat(ext(v_ff) + ext(mac_res));
                  end
                  STEP_DAMP: begin
                     dy_in    = sat(ext(z_ff) - ext(mac_res));
                     step_in  = STEP_LEVEL;
                     state_in = ST_ISSUE;
                  end
                  STEP_LEVEL: begin
                     y_in     = sat(ext(y_ff) + ext(mac_res));
                     step_in  = STEP_RATE;
                     state_in = ST_ISSUE;
                  end
                  STEP_RATE: begin
                     z_in     = sat(ext(z_ff) + ext(mac_res));
                     step_in  = STEP_OUT;
                     state_in = ST_ISSUE;
                  end
                  STEP_OUT: begin
                     x_in = sat(ext(x_ff) + ext(mac_res));
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_filtered_in = out_sat;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PASS;
         smoothing_ff <= '0;
         step_y_ff    <= '0;
         damp_y_ff    <= '0;
         gain_z_ff    <= '0;
         gain_x_ff    <= '0;
         init_ff      <= '0;
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_INIT_RATE;
         x_ff         <= '0;
         y_ff         <= '0;
         z_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         smoothing_ff <= smoothing_in;
         step_y_ff    <= step_y_in;
         damp_y_ff    <= damp_y_in;
         gain_z_ff    <= gain_z_in;
         gain_x_ff    <= gain_x_in;
         init_ff      <= init_in;
         state_ff     <= state_in;
         step_ff      <= step_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dy_ff           <= dy_in;
      delta_ff        <= delta_in;
      v_ff            <= v_in;
      rsp_filtered_ff <= rsp_filtered_in;
   end

   ssf_mac #(
      .STATE_BITS     (SB),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .operand (mac_operand),
      .coef    (mac_coef),
      .done    (mac_done),
      .result  (mac_res)
   );

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

endmodule

`default_nettype wire

// ===== src/ssf_mac.sv =====
// shared multiplier: rounded, saturated product of a state value and a coefficient
`default_nettype none

module ssf_mac
   import ssf_pkg::*;
#(
   parameter int STATE_BITS     = 48,
   parameter int COEF_FRAC_BITS = 30
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire mac_ctl_type              ctl,
   input  wire logic signed [STATE_BITS:0] operand,
   input  wire logic [COEF_BITS-1:0]     coef,
   output logic                          done,
   output logic signed [STATE_BITS-1:0]  result
);

   localparam int OPW  = STATE_BITS + 1;
   localparam int MAGW = (OPW > 32) ? OPW : 33;
   localparam int PW   = MAGW + COEF_BITS;

   localparam logic [PW:0] HALF_SMOOTH = (PW + 1)'(1) << (SMOOTH_FRAC_BITS - 1);
   localparam logic [PW:0] HALF_COEF   = (PW + 1)'(1) << (COEF_FRAC_BITS - 1);
   localparam logic [PW:0] LIM         = (PW + 1)'(1) << (STATE_BITS - 1);
   localparam logic signed [STATE_BITS-1:0] SMAX = {1'b0, {(STATE_BITS - 1){1'b1}}};
   localparam logic signed [STATE_BITS-1:0] SMIN = {1'b1, {(STATE_BITS - 1){1'b0}}};

   mac_phase_type phase_ff, phase_in;
   logic [MAGW-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic frac16_ff, frac16_in;
   logic [COEF_BITS-1:0] coef_ff, coef_in;
   logic [63:0] prod_ff, prod_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic signed [STATE_BITS-1:0] result_ff, result_in;
   logic done_ff, done_in;

   logic [OPW-1:0] abs_op;
   logic [31:0] mul_a;
   logic [PW:0] rnd_sum;
   logic [PW:0] quot;

   assign abs_op  = operand[OPW-1] ? (~operand + 1'b1) : operand;
   assign mul_a   = (phase_ff == MAC_HI) ? 32'(mag_ff[MAGW-1:32]) : mag_ff[31:0];
   assign prod_in = mul_a * coef_ff;
   assign rnd_sum = {1'b0, acc_ff} + (frac16_ff ? HALF_SMOOTH : HALF_COEF);
   assign quot    = frac16_ff ? (rnd_sum >> SMOOTH_FRAC_BITS) : (rnd_sum >> COEF_FRAC_BITS);

   always_comb begin
      phase_in  = phase_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      frac16_in = frac16_ff;
      coef_in   = coef_ff;
      acc_in    = acc_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      case (phase_ff)
         MAC_IDLE: begin
            if (ctl.start) begin
               mag_in    = MAGW'(abs_op);
               neg_in    = operand[OPW-1];
               frac16_in = ctl.frac16;
               coef_in   = coef;
               phase_in  = MAC_LO;
            end
         end
         MAC_LO: begin
            phase_in = MAC_HI;
         end
         MAC_HI: begin
            acc_in   = PW'(prod_ff);
            phase_in = MAC_ADD;
         end
         MAC_ADD: begin
            acc_in   = acc_ff + (PW'(prod_ff) << 32);
            phase_in = MAC_RND;
         end
         MAC_RND: begin
            if (quot >= LIM) begin
               result_in = neg_ff ? SMIN : SMAX;
            end else if (neg_ff) begin
               result_in = -$signed(quot[STATE_BITS-1:0]);
            end else begin
               result_in = $signed(quot[STATE_BITS-1:0]);
            end
            done_in  = 1'b1;
            phase_in = MAC_IDLE;
         end
         default: begin
            phase_in = MAC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MAC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      frac16_ff <= frac16_in;
      coef_ff   <= coef_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire
